// ===== design/pcot_pkg.sv =====
package pcot_pkg;

  localparam int unsigned WindowDepthDef = 12;

  localparam int unsigned CountW = 16;
  localparam int unsigned CfgW   = 4;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] RegRatio   = 1'b0;
  localparam logic [CfgIdxW-1:0] RegReplace = 1'b1;

  localparam logic [CfgW-1:0] RatioReset   = 4'd5;
  localparam logic [CfgW-1:0] ReplaceReset = 4'd3;

  typedef enum logic [1:0] {
    CLS_NORMAL = 2'd0,
    CLS_BIG    = 2'd1,
    CLS_SMALL  = 2'd2
  } cls_e;

endpackage

// ===== design/pcot_ram.sv =====
module pcot_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 12,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/pulse_count_outlier_tracker_top.sv =====
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+-------------------------------------
// count in  | input     | in_valid_i / in_stall_o | count_value_i
// result    | output    | out_valid_o / out_stall_i | count_class_o, window_average_o,
//           |           |                        | window_replaced_o
// config    | input     | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// each count runs a sweep of the normal window through the ram read port, then a
// restoring divider giving one quotient bit a cycle, then classify and write-back;
// the very first count skips sweep, divider and classify and goes straight to write-back
// reset clears all control and the per-entry valid bits, so both stores read as zero
// a new count is taken while a result still waits; write-back holds until the
// output register is free
module pulse_count_outlier_tracker_top
  import pcot_pkg::*;
#(
  parameter int unsigned WindowDepth = WindowDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CountW-1:0]   count_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          count_class_o,
  output logic [CountW-1:0]   window_average_o,
  output logic                window_replaced_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_wdata_i
);

  localparam int unsigned AddrW = $clog2(WindowDepth);
  localparam int unsigned IdxW  = $clog2(WindowDepth + 1);
  localparam int unsigned DivW  = $clog2(WindowDepth + 1);
  localparam int unsigned SumW  = CountW + $clog2(WindowDepth);
  localparam int unsigned StepW = $clog2(SumW);
  localparam int unsigned ProdW = SumW + CfgW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_CLASS,
    ST_UPDATE
  } state_e;

  state_e                 state_q;
  logic [CfgW-1:0]        ratio_q, replace_q;
  logic [CountW-1:0]      cnt_q;
  logic                   started_q, first_q;
  logic                   sel_q;
  logic [WindowDepth-1:0] nvld_q, avld_q;
  logic [AddrW-1:0]       nfill_q, afill_q;
  logic                   full_q;
  logic [3:0]             run_q;
  cls_e                   last_q, cls_q;
  logic [IdxW-1:0]        idx_q;
  logic [AddrW-1:0]       rd_idx_q;
  logic [SumW-1:0]        acc_q;
  logic [DivW-1:0]        rem_q, div_q;
  logic [StepW-1:0]       step_q;
  logic [CountW-1:0]      avg_q;
  logic                   out_valid_q, out_repl_q;
  cls_e                   out_cls_q;
  logic [CountW-1:0]      out_avg_q;

  // ram ports
  logic [1:0]        ram_we;
  logic [AddrW-1:0]  ram_waddr [2];
  logic [CountW-1:0] ram_rdata [2];
  logic [CountW-1:0] rdata;

  // divider step
  logic [DivW:0]   div_tmp;
  logic            div_ge;

  // classification
  logic [SumW-1:0]  avg_w;
  logic [ProdW-1:0] prod_c, prod_a, avg_x, cnt_x;
  cls_e             cls_w;

  // write-back decisions
  logic                   commit, is_norm, last_norm, nwe, awe, clr, repl;
  logic [3:0]             run_new;
  logic [AddrW-1:0]       afill_new, nfill_inc, afill_inc;
  logic [WindowDepth-1:0] avld_new;
  logic                   nbank, abank;

  assign nbank = sel_q;
  assign abank = ~sel_q;
  assign rdata = ram_rdata[nbank];

  assign nfill_inc = (nfill_q == AddrW'(WindowDepth - 1)) ? '0 : nfill_q + 1'b1;
  assign afill_inc = (afill_q == AddrW'(WindowDepth - 1)) ? '0 : afill_q + 1'b1;

  always_comb begin
    is_norm   = (cls_q == CLS_NORMAL);
    last_norm = (last_q == CLS_NORMAL);
    nwe       = first_q || (is_norm && last_norm);
    clr       = !first_q && !last_norm && (is_norm || (last_q != cls_q));
    awe       = !first_q && !is_norm && !clr;
    if (first_q) begin
      run_new = run_q;
    end else if (clr) begin
      run_new = '0;
    end else if (is_norm) begin
      run_new = run_q;
    end else begin
      run_new = run_q + 4'd1;
    end
    if (clr) begin
      afill_new = '0;
      avld_new  = '0;
    end else if (awe) begin
      afill_new = afill_inc;
      avld_new  = avld_q | (WindowDepth'(1) << afill_q);
    end else begin
      afill_new = afill_q;
      avld_new  = avld_q;
    end
    repl   = !first_q && !is_norm && (run_new == replace_q);
    commit = (state_q == ST_UPDATE) && (!out_valid_q || !out_stall_i);
  end

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      ram_we[b]    = commit && ((nwe && nbank == 1'(b)) || (awe && abank == 1'(b)));
      ram_waddr[b] = (nbank == 1'(b)) ? nfill_q : afill_q;
    end
  end

  for (genvar b = 0; b < 2; b++) begin : g_bank
    pcot_ram #(
      .Width(CountW),
      .Depth(WindowDepth)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (ram_we[b]),
      .waddr_i(ram_waddr[b]),
      .wdata_i(cnt_q),
      .raddr_i(idx_q[AddrW-1:0]),
      .rdata_o(ram_rdata[b])
    );
  end

  assign div_tmp = {rem_q, acc_q[SumW-1]};
  assign div_ge  = (div_tmp >= {1'b0, div_q});

  always_comb begin
    avg_w  = (div_q == '0) ? '0 : acc_q;
    prod_c = ProdW'(ratio_q) * ProdW'(cnt_q);
    prod_a = ProdW'(ratio_q) * ProdW'(avg_w);
    avg_x  = ProdW'(avg_w);
    cnt_x  = ProdW'(cnt_q);
    if (prod_c >= avg_x && cnt_x <= prod_a) begin
      cls_w = CLS_NORMAL;
    end else if (cnt_x > prod_a) begin
      cls_w = CLS_BIG;
    end else begin
      cls_w = CLS_SMALL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ratio_q     <= RatioReset;
      replace_q   <= ReplaceReset;
      cnt_q       <= '0;
      started_q   <= 1'b0;
      first_q     <= 1'b0;
      sel_q       <= 1'b0;
      nvld_q      <= '0;
      avld_q      <= '0;
      nfill_q     <= '0;
      afill_q     <= '0;
      full_q      <= 1'b0;
      run_q       <= '0;
      last_q      <= CLS_NORMAL;
      cls_q       <= CLS_NORMAL;
      idx_q       <= '0;
      rd_idx_q    <= '0;
      acc_q       <= '0;
      rem_q       <= '0;
      div_q       <= '0;
      step_q      <= '0;
      avg_q       <= '0;
      out_valid_q <= 1'b0;
      out_repl_q  <= 1'b0;
      out_cls_q   <= CLS_NORMAL;
      out_avg_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegRatio:   ratio_q   <= cfg_wdata_i;
          RegReplace: replace_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i && !commit) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            cnt_q <= count_value_i;
            idx_q <= '0;
            acc_q <= '0;
            if (!started_q) begin
              first_q <= 1'b1;
              cls_q   <= CLS_NORMAL;
              avg_q   <= '0;
              state_q <= ST_UPDATE;
            end else begin
              first_q <= 1'b0;
              state_q <= ST_SUM;
            end
          end
        end
        ST_SUM: begin
          // read data is registered and belongs to the previous address
          rd_idx_q <= idx_q[AddrW-1:0];
          idx_q    <= idx_q + 1'b1;
          if (idx_q != '0 && nvld_q[rd_idx_q]) begin
            acc_q <= acc_q + SumW'(rdata);
          end
          if (idx_q == IdxW'(WindowDepth)) begin
            div_q   <= full_q ? DivW'(WindowDepth) : DivW'(nfill_q);
            rem_q   <= '0;
            step_q  <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q  <= div_ge ? DivW'(div_tmp - {1'b0, div_q}) : div_tmp[DivW-1:0];
          acc_q  <= {acc_q[SumW-2:0], div_ge};
          step_q <= step_q + 1'b1;
          if (step_q == StepW'(SumW - 1)) begin
            state_q <= ST_CLASS;
          end
        end
        ST_CLASS: begin
          avg_q   <= avg_w[CountW-1:0];
          cls_q   <= cls_w;
          state_q <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (commit) begin
            out_valid_q <= 1'b1;
            out_cls_q   <= cls_q;
            out_avg_q   <= avg_q;
            out_repl_q  <= repl;
            state_q     <= ST_IDLE;
            started_q   <= 1'b1;
            if (nwe) begin
              nvld_q  <= nvld_q | (WindowDepth'(1) << nfill_q);
              nfill_q <= nfill_inc;
              if (nfill_q == AddrW'(WindowDepth - 1)) begin
                full_q <= 1'b1;
              end
            end
            if (repl) begin
              // swap banks: the abnormal store becomes the window, the old window is dropped
              sel_q   <= ~sel_q;
              nvld_q  <= avld_new;
              nfill_q <= afill_new;
              full_q  <= 1'b0;
              avld_q  <= '0;
              afill_q <= '0;
              run_q   <= '0;
              last_q  <= CLS_NORMAL;
            end else begin
              avld_q  <= avld_new;
              afill_q <= afill_new;
              run_q   <= run_new;
              if (!first_q) begin
                last_q <= cls_q;
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign count_class_o     = out_cls_q;
  assign window_average_o  = out_avg_q;
  assign window_replaced_o = out_repl_q;

endmodule
